// ----- rtl/cbl_pkg.sv -----
// Package for the connection flood blacklist: verdict and register codes,
// the search token that travels down the cell row, and the result record.
// No dependencies.
package cbl_pkg;

    localparam int ADDR_W   = 32;
    localparam int TIME_W   = 32;
    localparam int WINDOW_W = 16;
    localparam int WARN_W   = 5;
    localparam int VERD_W   = 2;
    localparam int IDX_W    = 8;

    localparam logic [VERD_W-1:0] VERDICT_ACCEPT = 2'd0;
    localparam logic [VERD_W-1:0] VERDICT_BANNED = 2'd1;
    localparam logic [VERD_W-1:0] VERDICT_NEWBAN = 2'd2;

    localparam logic [IDX_W-1:0] REG_WINDOW_MS     = 8'd0;
    localparam logic [IDX_W-1:0] REG_WARNING_LIMIT = 8'd1;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd1000;
    localparam logic [WARN_W-1:0]   LIMIT_RESET  = 5'd25;

    typedef struct packed {
        logic [WINDOW_W-1:0] window_ms;
        logic [WARN_W-1:0]   warning_limit;
    } cbl_cfg_t;

    // busy: token present; done: some cell has resolved the attempt
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] now;
        logic [VERD_W-1:0] verdict;
        logic [WARN_W-1:0] warn;
    } cbl_tok_t;

    typedef struct packed {
        logic [VERD_W-1:0] verdict;
        logic              not_recorded;
        logic [WARN_W-1:0] warnings_now;
    } cbl_res_t;

endpackage

// ----- rtl/cbl_cell.sv -----
// One table entry of the blacklist plus one stage of the search token row.
// Depends on cbl_pkg.
module cbl_cell
    import cbl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cbl_cfg_t cfg,
    input  cbl_tok_t tok_in,
    output cbl_tok_t tok_out
);

    logic              valid_reg, valid_next;
    logic [ADDR_W-1:0] address_reg, address_next;
    logic [TIME_W-1:0] last_reg, last_next;
    logic [WARN_W-1:0] warn_reg, warn_next;
    logic              banned_reg, banned_next;
    cbl_tok_t          tok_reg, tok_next;

    logic              active;
    logic              hit;
    logic [TIME_W-1:0] elapsed;
    logic              fast;

    assign active  = tok_in.busy && !tok_in.done;
    assign hit     = valid_reg && (address_reg == tok_in.addr);
    assign elapsed = tok_in.now - last_reg;
    assign fast    = elapsed < {{(TIME_W-WINDOW_W){1'b0}}, cfg.window_ms};

    always_comb
    begin
        valid_next   = valid_reg;
        address_next = address_reg;
        last_next    = last_reg;
        warn_next    = warn_reg;
        banned_next  = banned_reg;
        tok_next     = tok_in;
        if (active && hit)
        begin
            tok_next.done    = 1'b1;
            tok_next.verdict = VERDICT_ACCEPT;
            tok_next.warn    = warn_reg;
            priority if (banned_reg)
            begin
                tok_next.verdict = VERDICT_BANNED;
            end
            else if (fast)
            begin
                if (warn_reg >= cfg.warning_limit)
                begin
                    banned_next      = 1'b1;
                    tok_next.verdict = VERDICT_NEWBAN;
                end
                else
                begin
                    warn_next     = warn_reg + 1'b1;
                    tok_next.warn = warn_reg + 1'b1;
                end
            end
            else
            begin
                last_next = tok_in.now;
            end
        end
        else if (active && !valid_reg)
        begin
            // valid entries form a prefix, so the first free cell is the insert point
            valid_next       = 1'b1;
            address_next     = tok_in.addr;
            last_next        = tok_in.now;
            warn_next        = '0;
            banned_next      = 1'b0;
            tok_next.done    = 1'b1;
            tok_next.verdict = VERDICT_ACCEPT;
            tok_next.warn    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        address_reg      <= address_next;
        last_reg         <= last_next;
        warn_reg         <= warn_next;
        banned_reg       <= banned_next;
    end

    assign tok_out = tok_reg;

endmodule

// ----- rtl/connection_flood_blacklist_core.sv -----
// Flow: an accepted input beat becomes a search token that walks the cell row
//   one entry per cycle, then its verdict is registered in the output stage.
//   Only one token is in flight; in_stall holds new attempts off while busy.
// Reset: all entries invalid, window_ms = 1000, warning_limit = 25, no beat
//   pending. Entry payload is not reset; the valid bits guard it.
// Top level of the connection flood blacklist. Depends on cbl_pkg, cbl_cell.
module connection_flood_blacklist_core
    import cbl_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    // attempt channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [ADDR_W-1:0]   source_address,
    input  logic [TIME_W-1:0]   now_ms,
    // verdict channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic [VERD_W-1:0]   verdict,
    output logic                not_recorded,
    output logic [WARN_W-1:0]   warnings_now,
    // register write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [WINDOW_W-1:0] cfg_data
);

    // ---------------------------------------------------------------
    // Configuration registers; the cells read them live, so writes are
    // expected only while no search is in flight
    // ---------------------------------------------------------------
    cbl_cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_WINDOW_MS)
                cfg_next.window_ms = cfg_data;
            else if (cfg_index == REG_WARNING_LIMIT)
                cfg_next.warning_limit = cfg_data[WARN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_ms     <= WINDOW_RESET;
            cfg_reg.warning_limit <= LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------------------------------------------------------
    // Input side: one attempt at a time. busy_reg covers the token's
    // walk; pend_valid_reg holds a verdict that found the output full.
    // ---------------------------------------------------------------
    logic     busy_reg, busy_next;
    logic     pend_valid_reg, pend_valid_next;
    logic     in_accept;
    cbl_tok_t inject;

    assign in_stall  = busy_reg || pend_valid_reg;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        inject.busy    = in_accept;
        inject.done    = 1'b0;
        inject.addr    = source_address;
        inject.now     = now_ms;
        inject.verdict = VERDICT_ACCEPT;
        inject.warn    = '0;
    end

    // ---------------------------------------------------------------
    // Cell row: cell i owns entry i and hands the token to cell i+1
    // ---------------------------------------------------------------
    cbl_tok_t              tok [TABLE_DEPTH+1];
    logic [TABLE_DEPTH-1:0] tok_busy;

    assign tok[0] = inject;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        cbl_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .cfg     (cfg_reg),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
        assign tok_busy[i] = tok[i+1].busy;
    end

    // token leaving the last cell; unresolved means the table was full
    logic     exit_beat;
    cbl_res_t exit_res;

    assign exit_beat = tok[TABLE_DEPTH].busy;

    always_comb
    begin
        exit_res.verdict      = tok[TABLE_DEPTH].done ? tok[TABLE_DEPTH].verdict
                                                      : VERDICT_ACCEPT;
        exit_res.not_recorded = !tok[TABLE_DEPTH].done;
        exit_res.warnings_now = tok[TABLE_DEPTH].done ? tok[TABLE_DEPTH].warn : '0;
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (in_accept)
            busy_next = 1'b1;
        else if (exit_beat)
            busy_next = 1'b0;
    end

    // ---------------------------------------------------------------
    // Output register with a one-deep pending slot behind it
    // ---------------------------------------------------------------
    logic     out_valid_reg, out_valid_next;
    cbl_res_t out_res_reg, out_res_next;
    cbl_res_t pend_res_reg, pend_res_next;
    logic     out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        pend_valid_next = pend_valid_reg;
        pend_res_next   = pend_res_reg;
        if (out_free)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_res_next    = pend_res_reg;
                pend_valid_next = 1'b0;
            end
            else if (exit_beat)
            begin
                out_valid_next = 1'b1;
                out_res_next   = exit_res;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (exit_beat)
        begin
            pend_valid_next = 1'b1;
            pend_res_next   = exit_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        pend_res_reg <= pend_res_next;
    end

    assign out_valid    = out_valid_reg;
    assign verdict      = out_res_reg.verdict;
    assign not_recorded = out_res_reg.not_recorded;
    assign warnings_now = out_res_reg.warnings_now;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_busy))
        else $error("more than one token in the cell row");

    a_token_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_busy != '0) |-> busy_reg)
        else $error("token in flight while not busy");

    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("pending verdict with empty output register");

    a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (busy_reg && tok_busy[0]))
        else $error("accepted beat did not enter the cell row");

endmodule

// ----- tb/sv/cbl_verdict_board.sv -----
// Verdict scoreboard for the connection flood blacklist bench: a shadow of
// the source table and registers, plus the queue of verdicts still owed.
// Depends on cbl_pkg for widths, verdict codes and register indexes.
`timescale 1ns / 1ps
package cbl_tb_pkg;
    import cbl_pkg::*;

    localparam int BOARD_DEPTH = 64;

    class verdict_board;
        logic [WINDOW_W-1:0] window_ms;
        logic [WARN_W-1:0]   warn_limit;

        bit                  slot_used   [BOARD_DEPTH];
        logic [ADDR_W-1:0]   slot_addr   [BOARD_DEPTH];
        logic [TIME_W-1:0]   slot_last   [BOARD_DEPTH];
        logic [WARN_W-1:0]   slot_warn   [BOARD_DEPTH];
        bit                  slot_banned [BOARD_DEPTH];

        cbl_res_t pending_verdicts[$];

        int errors;
        int verdicts_seen;
        int n_inserted;
        int n_refreshed;
        int n_warned;
        int n_newban;
        int n_rejected;
        int n_unrecorded;
        int n_cfg_writes;

        function new();
            window_ms  = WINDOW_RESET;
            warn_limit = LIMIT_RESET;
            foreach (slot_used[i])
            begin
                slot_used[i] = 1'b0;
            end
        endfunction

        function void note_config(logic [IDX_W-1:0] idx, logic [WINDOW_W-1:0] data);
            n_cfg_writes++;
            if (idx == REG_WINDOW_MS)
                window_ms = data;
            else if (idx == REG_WARNING_LIMIT)
                warn_limit = data[WARN_W-1:0];
        endfunction

        // Judge one accepted attempt and queue the verdict it must produce.
        function void note_attempt(logic [ADDR_W-1:0] addr, logic [TIME_W-1:0] stamp);
            cbl_res_t          res;
            int                hit;
            int                free_slot;
            logic [TIME_W-1:0] elapsed;
            res       = '0;
            res.verdict = VERDICT_ACCEPT;
            hit       = -1;
            free_slot = -1;
            for (int i = 0; i < BOARD_DEPTH; i++)
            begin
                if (slot_used[i])
                begin
                    if (hit < 0 && slot_addr[i] == addr)
                        hit = i;
                end
                else if (free_slot < 0)
                begin
                    free_slot = i;
                end
            end
            if (hit >= 0)
            begin
                elapsed = stamp - slot_last[hit];
                if (slot_banned[hit])
                begin
                    res.verdict = VERDICT_BANNED;
                    n_rejected++;
                end
                else if (elapsed < window_ms)
                begin
                    if (slot_warn[hit] >= warn_limit)
                    begin
                        slot_banned[hit] = 1'b1;
                        res.verdict      = VERDICT_NEWBAN;
                        n_newban++;
                    end
                    else
                    begin
                        slot_warn[hit] = slot_warn[hit] + 1'b1;
                        n_warned++;
                    end
                end
                else
                begin
                    slot_last[hit] = stamp;
                    n_refreshed++;
                end
                res.warnings_now = slot_warn[hit];
            end
            else if (free_slot >= 0)
            begin
                slot_used[free_slot]   = 1'b1;
                slot_addr[free_slot]   = addr;
                slot_last[free_slot]   = stamp;
                slot_warn[free_slot]   = '0;
                slot_banned[free_slot] = 1'b0;
                n_inserted++;
            end
            else
            begin
                res.not_recorded = 1'b1;
                n_unrecorded++;
            end
            pending_verdicts = {pending_verdicts, res};
        endfunction

        function void compare_field(string what, int want, int got);
            if (want != got)
            begin
                errors++;
                $display("[%0t] %s mismatch: expected %0d, actual %0d", $time, what, want, got);
            end
        endfunction

        function void check_verdict(logic [VERD_W-1:0] verdict, logic not_recorded,
                                    logic [WARN_W-1:0] warnings_now);
            cbl_res_t want;
            verdicts_seen++;
            if (pending_verdicts.size() == 0)
            begin
                errors++;
                $display("[%0t] verdict beat with none owed: expected nothing, actual %0d/%0d/%0d",
                         $time, verdict, not_recorded, warnings_now);
                return;
            end
            want = pending_verdicts.pop_front();
            compare_field("verdict", int'(want.verdict), int'(verdict));
            compare_field("not_recorded", int'(want.not_recorded), int'(not_recorded));
            compare_field("warnings_now", int'(want.warnings_now), int'(warnings_now));
        endfunction
    endclass

endpackage

// ----- tb/sv/tb_connection_flood_blacklist_core.sv -----
// Bench for connection_flood_blacklist_core: drives attempt beats and register
// writes, shadows the source table in a scoreboard, checks every verdict beat.
// Depends on cbl_pkg and cbl_tb_pkg (cbl_verdict_board.sv).
`timescale 1ns / 1ps
module tb_connection_flood_blacklist_core;
    import cbl_pkg::*;
    import cbl_tb_pkg::*;

    // Slowest legal run is roughly 1400 beats, each with a full table search, the longest
    // idle gap and output stalls, plus one long hold; the limit sits about five times above that.
    localparam int CYCLE_LIMIT = 1200000;

    // Register indexes the block must ignore.
    localparam logic [IDX_W-1:0] REG_SPARE = REG_WARNING_LIMIT + 1'b1;
    localparam logic [IDX_W-1:0] REG_TOP   = '1;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [ADDR_W-1:0]   source_address;
    logic [TIME_W-1:0]   now_ms;
    logic                out_valid;
    logic                out_stall;
    logic [VERD_W-1:0]   verdict;
    logic                not_recorded;
    logic [WARN_W-1:0]   warnings_now;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index;
    logic [WINDOW_W-1:0] cfg_data;

    verdict_board      board;
    int                attempts_sent = 0;
    int                burst_left    = 0;
    int                cycle_count   = 0;
    logic [TIME_W-1:0] clock_ms;
    logic [ADDR_W-1:0] known_sources[$];

    connection_flood_blacklist_core #(.TABLE_DEPTH(BOARD_DEPTH)) dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .source_address (source_address),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .verdict        (verdict),
        .not_recorded   (not_recorded),
        .warnings_now   (warnings_now),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #6 clk = ~clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d verdicts still owed",
                     cycle_count, board.pending_verdicts.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Every verdict beat is checked against the oldest owed verdict.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_verdict(verdict, not_recorded, warnings_now);
    end

    // Verdict sink. Stall pattern changes after each random-length run; once the
    // sender has gotten going it refuses beats for one long hold so the single
    // search slot backs up and in_stall has to hold the sender off.
    initial
    begin : verdict_sink
        int hold_left;
        int run_left;
        int mode;
        bit long_hold_done;
        out_stall      = 1'b0;
        hold_left      = 0;
        run_left       = 0;
        mode           = 0;
        long_hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && attempts_sent >= 400)
            begin
                long_hold_done = 1'b1;
                hold_left      = 600;
            end
            if (run_left == 0)
            begin
                mode     = $urandom_range(0, 3);
                run_left = $urandom_range(20, 300);
            end
            run_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                case (mode)
                    0:       out_stall <= 1'b0;                          // free flow
                    1:       out_stall <= ($urandom_range(0, 1) == 1);   // coin flip
                    2:       out_stall <= (run_left % 4) != 0;           // mostly blocked
                    default: out_stall <= (run_left % 13) < 2;           // short blips
                endcase
            end
        end
    end

    function automatic logic [ADDR_W-1:0] fresh_source();
        logic [ADDR_W-1:0] addr;
        addr = $urandom;
        known_sources = {known_sources, addr};
        return addr;
    endfunction

    // One attempt beat. Bursts keep in_valid high back to back; between
    // bursts the sender idles for a random gap so idles land on every phase
    // of the table search.
    task automatic offer_attempt(input logic [ADDR_W-1:0] addr, input logic [TIME_W-1:0] stamp);
        int gap;
        @(negedge clk);
        in_valid       <= 1'b1;
        source_address <= addr;
        now_ms         <= stamp;
        do @(posedge clk); while (in_stall);
        board.note_attempt(addr, stamp);
        attempts_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 6);
            gap = $urandom_range(0, 90);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Drop in_valid and wait until every owed verdict has come back; each
    // attempt yields exactly one verdict, so the block is idle after that.
    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [WINDOW_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        board.note_config(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        known_sources = {known_sources, 32'h0000_0000};
        known_sources = {known_sources, 32'hFFFF_FFFF};
        known_sources = {known_sources, 32'hA5A5_5A5A};
        known_sources = {known_sources, 32'h1234_5678};
        known_sources = {known_sources, 32'h5A5A_A5A5};
        // reset settings: window 1000, limit 25
        offer_attempt(32'h0000_0000, 32'd0);
        offer_attempt(32'h0000_0000, 32'd999);          // one inside window: warning
        offer_attempt(32'h0000_0000, 32'd1000);         // warning kept old time: refresh
        offer_attempt(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_attempt(32'hFFFF_FFFF, 32'h0000_0010);    // clock wrapped, still fast
        offer_attempt(32'hFFFF_FFFF, 32'h8000_0000);
        settle_block();
        write_reg(REG_WINDOW_MS, 16'd100);
        write_reg(REG_WARNING_LIMIT, 16'hFFE1);         // upper bits dropped, limit 1
        write_reg(REG_SPARE, 16'h0000);
        write_reg(REG_TOP, 16'hFFFF);
        offer_attempt(32'hA5A5_5A5A, 32'h0000_1000);
        offer_attempt(32'hA5A5_5A5A, 32'h0000_1010);
        offer_attempt(32'hA5A5_5A5A, 32'h0000_1020);    // at limit: new ban
        offer_attempt(32'hA5A5_5A5A, 32'h9000_0000);    // banned stays banned
        offer_attempt(32'h0000_0000, 32'd1050);         // count from before lowering
        settle_block();
        write_reg(REG_WINDOW_MS, 16'd0);
        write_reg(REG_WARNING_LIMIT, 16'd0);
        offer_attempt(32'h1234_5678, 32'd5);
        offer_attempt(32'h1234_5678, 32'd5);            // zero window: refresh only
        offer_attempt(32'hFFFF_FFFF, 32'h8000_0000);
        settle_block();
        write_reg(REG_WINDOW_MS, 16'hFFFF);
        offer_attempt(32'h1234_5678, 32'd6);            // zero limit: first fast return bans
        offer_attempt(32'h5A5A_A5A5, 32'h7FFF_FFFF);
        offer_attempt(32'h5A5A_A5A5, 32'h8000_FFFE);    // gap equals window
        offer_attempt(32'h5A5A_A5A5, 32'h8001_FFFC);
    endtask

    // Random phase under one register setting. Most beats come from a small
    // hot set so sources cycle through warnings, refreshes and bans.
    task automatic run_phase(input int wnd, input int lim, input int count, input int new_pct);
        int                r;
        logic [10:0]       junk;
        logic [ADDR_W-1:0] hot [6];
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] stamp;
        settle_block();
        junk = 11'($urandom_range(0, 2047));
        write_reg(REG_WINDOW_MS, wnd[WINDOW_W-1:0]);
        write_reg(REG_WARNING_LIMIT, {junk, lim[WARN_W-1:0]});
        foreach (hot[i])
        begin
            if (i < 2 || known_sources.size() == 0)
                hot[i] = fresh_source();
            else
                hot[i] = known_sources[$urandom_range(0, known_sources.size() - 1)];
        end
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < new_pct)
                addr = fresh_source();
            else if (r < new_pct + 70)
                addr = hot[$urandom_range(0, 5)];
            else
                addr = known_sources[$urandom_range(0, known_sources.size() - 1)];
            r = $urandom_range(0, 99);
            if (r < 70)
                clock_ms = clock_ms + $urandom_range(0, wnd / 8);
            else if (r < 92)
                clock_ms = clock_ms + $urandom_range(0, wnd);
            else if (r < 98)
                clock_ms = clock_ms + $urandom;
            // last two percent: a stray timestamp off the running clock
            stamp = (r >= 98) ? $urandom : clock_ms;
            offer_attempt(addr, stamp);
        end
    endtask

    initial
    begin
        board          = new();
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        source_address = '0;
        now_ms         = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        clock_ms       = 32'hFFF0_0000;   // wraps early in the random part
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        // window, limit, beats, percent of never-seen sources
        run_phase(1000,  25, 200,  5);
        run_phase(65535, 31, 150,  5);
        run_phase(0,      0, 120,  5);
        run_phase(300,    3, 200, 30);   // flood of new sources fills the table
        run_phase(1,      1, 150,  5);
        run_phase(5000,  10, 200,  8);
        run_phase(65535,  0, 100,  5);
        run_phase(1000,  25, 260, 10);

        settle_block();
        repeat (BOARD_DEPTH + 16) @(posedge clk);

        $display("covered %0d attempts, %0d register writes: %0d inserted, %0d refreshed, %0d warned",
                 attempts_sent, board.n_cfg_writes, board.n_inserted, board.n_refreshed,
                 board.n_warned);
        $display("%0d newly banned, %0d rejected as banned, %0d unrecorded, %0d verdicts checked",
                 board.n_newban, board.n_rejected, board.n_unrecorded, board.verdicts_seen);
        if (board.pending_verdicts.size() != 0)
            $display("%0d verdicts never arrived", board.pending_verdicts.size());
        if (board.errors == 0 && board.pending_verdicts.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/cbl_pkg.sv
rtl/cbl_cell.sv
rtl/connection_flood_blacklist_core.sv
tb/sv/cbl_verdict_board.sv
tb/sv/tb_connection_flood_blacklist_core.sv
